// File: sv/ulcm_pkg.sv
package ulcm_pkg;

    localparam int KEY_COUNT = 6;
    localparam int KEY_MAX   = 23;
    localparam int IDX_W     = 5;

    typedef logic [2:0]       func_t;
    typedef logic [IDX_W-1:0] key_idx_t;
    typedef logic [31:0][7:0] key_text_t;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Byte 0 of each entry is the last character of the keyword.
    localparam key_text_t KEY_TEXT [KEY_COUNT] = '{
        {"led_shift_", "left_on"},
        {"led_shift_", "right_on"},
        {"led_shift_", "left_keep_on"},
        {"led_shift_", "right_keep_on"},
        {"led_", "flower_on"},
        {"led_", "flower_off"}
    };

    localparam key_idx_t KEY_LEN [KEY_COUNT] = '{
        5'd17, 5'd18, 5'd22, 5'd23, 5'd13, 5'd14
    };

    typedef struct packed {
        logic     clear;
        logic     valid;
        key_idx_t idx;
    } cmp_ctl_t;

    // Character j (from the start) of keyword k.
    function automatic logic [7:0] key_byte(input int unsigned k, input key_idx_t j);
        key_idx_t pos;
        pos = KEY_LEN[k] - 5'd1 - j;
        return KEY_TEXT[k][pos];
    endfunction

endpackage

// File: sv/ulcm_item_if.sv
interface ulcm_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// File: sv/ulcm_result_if.sv
interface ulcm_result_if;
    import ulcm_pkg::*;

    logic       valid;
    logic       ready;
    func_t      func_code;
    logic       line_taken;
    logic       keyword_hit;
    logic       byte_dropped;
    logic [2:0] lines_waiting;

    modport source (
        output valid, output func_code, output line_taken, output keyword_hit,
        output byte_dropped, output lines_waiting, input ready
    );
    modport sink (
        input valid, input func_code, input line_taken, input keyword_hit,
        input byte_dropped, input lines_waiting, output ready
    );
endinterface

// File: sv/ulcm_key_check.sv
module ulcm_key_check #(
    parameter int LEN_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ulcm_pkg::cmp_ctl_t ctl,
    input  logic [7:0]        data,
    input  logic [LEN_W-1:0]  len,
    output logic              hit,
    output ulcm_pkg::func_t   code
);
    import ulcm_pkg::*;

    logic [KEY_COUNT-1:0] match_reg;
    logic [KEY_COUNT-1:0] match_next;
    logic [KEY_COUNT-1:0] full;

    // Knock out a keyword as soon as one of its characters differs.
    always_comb
    begin
        match_next = match_reg;
        if (ctl.clear)
        begin
            match_next = '1;
        end
        else if (ctl.valid)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                if ((ctl.idx < KEY_LEN[k]) && (data != key_byte(k, ctl.idx)))
                begin
                    match_next[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '1;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // A keyword hits only if the line is at least as long; lowest index wins.
    always_comb
    begin
        hit  = 1'b0;
        code = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            full[k] = match_reg[k] && (32'(len) >= 32'(KEY_LEN[k]));
            if (full[k])
            begin
                hit  = 1'b1;
                code = func_t'(k);
            end
        end
    end

endmodule

// File: sv/uart_line_queue_command_matcher.sv
// Byte word: accepted and answered via the output register; a new word may follow
// each cycle while that register is free or taken. Service word with a stored
// line: 23 keyword character reads from the line memory, one per cycle, then read
// latency and decision. Empty ring: answered without a scan. One word is in work at a time.
// Reset clears slot pointers, fill position, selected function and output valid;
// line memory contents are undefined until written and need no clearing pass.
module uart_line_queue_command_matcher #(
    parameter int LINE_SLOTS = 8,
    parameter int LINE_BYTES = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ulcm_item_if.sink     item,
    ulcm_result_if.source result
);
    import ulcm_pkg::*;

    localparam int SLOT_W = $clog2(LINE_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CI_W   = $clog2(LINE_BYTES);
    localparam int DEPTH  = LINE_SLOTS * LINE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // Line characters and per-slot line lengths.
    logic [7:0]      line_mem [DEPTH];
    logic [CI_W-1:0] len_mem  [LINE_SLOTS];

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic [CI_W-1:0]   ci_reg, ci_next;
    func_t             func_reg, func_next;
    key_idx_t          j_reg, j_next;
    logic              cmp_valid_reg, cmp_valid_next;
    key_idx_t          cmp_idx_reg, cmp_idx_next;

    logic [7:0]        rd_data_reg;
    logic [CI_W-1:0]   len_rd_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              char_we;
    logic              len_we;

    // Output register.
    logic       out_valid_reg;
    logic       out_load;
    logic       taken_reg, taken_next;
    logic       hit_reg, hit_next;
    logic       drop_reg, drop_next;
    logic [2:0] wait_reg, wait_next;

    logic       accept;
    logic       ring_full;
    logic       key_hit;
    func_t      key_code;
    cmp_ctl_t   cmp_ctl;
    logic [CNT_W-1:0] diff;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign item.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign ring_full  = (next_slot(ws_reg) == rs_reg);

    assign rd_addr = ADDR_W'(rs_reg) * ADDR_W'(LINE_BYTES) + ADDR_W'(j_reg);
    assign wr_addr = ADDR_W'(ws_reg) * ADDR_W'(LINE_BYTES) + ADDR_W'(ci_reg);

    assign cmp_ctl.clear = accept && item.mode;
    assign cmp_ctl.valid = cmp_valid_reg;
    assign cmp_ctl.idx   = cmp_idx_reg;

    ulcm_key_check #(
        .LEN_W (CI_W)
    ) u_key_check (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cmp_ctl),
        .data  (rd_data_reg),
        .len   (len_rd_reg),
        .hit   (key_hit),
        .code  (key_code)
    );

    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        rs_next        = rs_reg;
        ci_next        = ci_reg;
        func_next      = func_reg;
        j_next         = j_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        char_we        = 1'b0;
        len_we         = 1'b0;
        out_load       = 1'b0;
        taken_next     = 1'b0;
        hit_next       = 1'b0;
        drop_next      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!item.mode)
                    begin
                        out_load = 1'b1;
                        if (ring_full)
                        begin
                            drop_next = 1'b1;
                        end
                        else if ((item.rx_byte == CH_LF) || (item.rx_byte == CH_CR))
                        begin
                            // Close the line: record its length, advance the slot.
                            len_we  = 1'b1;
                            ci_next = '0;
                            ws_next = next_slot(ws_reg);
                        end
                        else if (ci_reg >= CI_W'(LINE_BYTES - 1))
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            char_we = 1'b1;
                            ci_next = ci_reg + 1'b1;
                        end
                    end
                    else if (rs_reg == ws_reg)
                    begin
                        // Nothing to pop.
                        out_load = 1'b1;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one character read per cycle; compare it in the next cycle.
                cmp_valid_next = 1'b1;
                cmp_idx_next   = j_reg;
                if (j_reg == key_idx_t'(KEY_MAX - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                out_load   = 1'b1;
                taken_next = 1'b1;
                hit_next   = key_hit;
                rs_next    = next_slot(rs_reg);
                if (key_hit)
                begin
                    func_next = key_code;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Complete lines held after this word, saturated at 7.
        if (ws_next >= rs_next)
        begin
            diff = CNT_W'(ws_next) - CNT_W'(rs_next);
        end
        else
        begin
            diff = CNT_W'(ws_next) + CNT_W'(LINE_SLOTS) - CNT_W'(rs_next);
        end
        wait_next = (32'(diff) > 7) ? 3'd7 : 3'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            rs_reg        <= '0;
            ci_reg        <= '0;
            func_reg      <= '0;
            j_reg         <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            ci_reg        <= ci_next;
            func_reg      <= func_next;
            j_reg         <= j_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next load.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            taken_reg <= taken_next;
            hit_reg   <= hit_next;
            drop_reg  <= drop_next;
            wait_reg  <= wait_next;
        end
    end

    // Line memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            line_mem[wr_addr] <= item.rx_byte;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // Length memory: written on line close, read at the oldest slot.
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[ws_reg] <= ci_reg;
        end
        len_rd_reg <= len_mem[rs_reg];
    end

    assign result.valid         = out_valid_reg;
    assign result.func_code     = func_reg;
    assign result.line_taken    = taken_reg;
    assign result.keyword_hit   = hit_reg;
    assign result.byte_dropped  = drop_reg;
    assign result.lines_waiting = wait_reg;

    // A keyword hit only comes with a popped line.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.keyword_hit |-> result.line_taken)
    else $error("keyword hit without popped line");

    // No input word is taken while a line scan is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !item.ready)
    else $error("input ready during scan");

    // The scan result must find the output register free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !out_valid_reg)
    else $error("scan result would overwrite pending word");

    // A scan only starts on a non-empty ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rs_reg != ws_reg))
    else $error("scan on empty ring");

endmodule
